// File: rtl/core/tslf_pkg.sv
// Package for the text stream line formatter: shared types, character codes,
// configuration register indexes and the per-byte expansion function.
// No dependencies.
`timescale 1ns / 1ps

package tslf_pkg;

    localparam int LINE_DIGITS_DEF = 6;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_SQUEEZE_BLANK    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_NONBLANK  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_ALL       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOW_ENDS        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOW_TABS        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOW_NONPRINTING = 3'd5;

    localparam logic [7:0] CH_NL     = 8'd10;
    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_ZERO   = 8'd48;
    localparam logic [7:0] CH_DOLLAR = 8'd36;
    localparam logic [7:0] CH_CARET  = 8'd94;
    localparam logic [7:0] CH_M      = 8'd77;
    localparam logic [7:0] CH_DASH   = 8'd45;
    localparam logic [7:0] CH_QMARK  = 8'd63;
    localparam logic [7:0] CH_I      = 8'd73;
    localparam logic [7:0] CH_DEL    = 8'd127;
    localparam logic [7:0] CH_HI_LO  = 8'd128;
    localparam logic [7:0] CH_META   = 8'd160;
    localparam logic [7:0] CH_FF     = 8'd255;
    localparam logic [7:0] CTRL_OFS  = 8'd64;

    typedef struct packed {
        logic squeeze_blank;
        logic number_nonblank;
        logic number_all;
        logic show_ends;
        logic show_tabs;
        logic show_nonprinting;
    } t_cfg;

    // Expansion of the raw byte itself; the first byte sits in bytes[3].
    typedef struct packed {
        logic [2:0]      len;
        logic [3:0][7:0] bytes;
    } t_exp;

    // Control part of one item's output sequence (the digits travel apart).
    typedef struct packed {
        logic has_pfx;
        logic dollar;
        t_exp exp;
    } t_desc;

    function automatic t_exp f_expand(input logic [7:0] ch, input logic tabs,
                                      input logic np);
        t_exp e;
        e.len      = 3'd1;
        e.bytes    = '0;
        e.bytes[3] = ch;
        if (tabs && ch == CH_TAB) begin
            e.len   = 3'd2;
            e.bytes = {CH_CARET, CH_I, 16'h0000};
        end else if (np && ch < CH_SPACE && ch != CH_NL && ch != CH_TAB) begin
            e.len   = 3'd2;
            e.bytes = {CH_CARET, ch + CTRL_OFS, 16'h0000};
        end else if (np && ch == CH_DEL) begin
            e.len   = 3'd2;
            e.bytes = {CH_CARET, CH_QMARK, 16'h0000};
        end else if (np && ch >= CH_HI_LO && ch < CH_META) begin
            e.len   = 3'd4;
            e.bytes = {CH_M, CH_DASH, CH_CARET, ch - CTRL_OFS};
        end else if (np && ch >= CH_META && ch < CH_FF) begin
            e.len   = 3'd3;
            e.bytes = {CH_M, CH_DASH, ch - CH_HI_LO, 8'h00};
        end else if (np && ch == CH_FF) begin
            e.len   = 3'd4;
            e.bytes = {CH_M, CH_DASH, CH_CARET, CH_QMARK};
        end
        return e;
    endfunction

endpackage

// File: rtl/core/tslf_front.sv
// Front stage of the line formatter: line state (previous byte, BCD line
// counter, blank-line run) and the descriptor of each item's output.
// Depends on tslf_pkg.
`timescale 1ns / 1ps

module tslf_front #(
    parameter int LINE_DIGITS = tslf_pkg::LINE_DIGITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  tslf_pkg::t_cfg             i_cfg,
    input  logic                       i_accept,
    input  logic [7:0]                 i_in_byte,
    input  logic                       i_start_of_file,
    output logic                       o_load,
    output tslf_pkg::t_desc            o_desc,
    output logic [8*LINE_DIGITS-1:0]   o_pfx
);

    localparam int CW = 4 * LINE_DIGITS;
    localparam logic [CW-1:0] CNT_ONE = CW'(1);

    logic [7:0]    r_prev_byte;
    logic [CW-1:0] r_line_count;
    logic [1:0]    r_blank_run;

    logic [7:0]    eff_prev;
    logic [CW-1:0] eff_cnt;
    logic [1:0]    eff_blank;
    logic          prev_nl;
    logic          ch_nl;
    logic          sq_hit;
    logic [1:0]    n_blank_run;
    logic          drop;
    logic          do_num;
    logic          blank_pfx;
    logic [CW-1:0] cnt_inc;
    logic [LINE_DIGITS-1:0] nine;
    logic [LINE_DIGITS-1:0] below_nine;
    logic          full;

    assign eff_prev  = i_start_of_file ? tslf_pkg::CH_NL : r_prev_byte;
    assign eff_cnt   = i_start_of_file ? CNT_ONE : r_line_count;
    assign eff_blank = i_start_of_file ? 2'd0 : r_blank_run;
    assign prev_nl   = (eff_prev == tslf_pkg::CH_NL);
    assign ch_nl     = (i_in_byte == tslf_pkg::CH_NL);

    assign sq_hit      = i_cfg.squeeze_blank && prev_nl && ch_nl;
    assign n_blank_run = !sq_hit ? 2'd0 : ((eff_blank == 2'd3) ? 2'd3 : eff_blank + 2'd1);
    assign drop        = sq_hit && (n_blank_run > 2'd1);

    assign do_num = !drop && (i_cfg.number_nonblank ? (prev_nl && !ch_nl)
                                                    : (i_cfg.number_all && prev_nl));
    assign blank_pfx = !drop && i_cfg.show_ends && ch_nl && prev_nl
                       && i_cfg.number_nonblank;

    // Per-digit prefix characters and BCD increment.
    for (genvar i = 0; i < LINE_DIGITS; i++) begin : g_dig
        logic [3:0] d;
        logic       lead;
        assign d       = eff_cnt[4*i +: 4];
        assign nine[i] = (d == 4'd9);
        assign lead    = (eff_cnt[CW-1:4*i] == '0) && (i != 0);
        assign o_pfx[8*i +: 8] = (blank_pfx || lead) ? tslf_pkg::CH_SPACE
                                                     : (tslf_pkg::CH_ZERO | {4'h0, d});
        if (i == 0) begin : g_lsd
            assign below_nine[i] = 1'b1;
        end else begin : g_upper
            assign below_nine[i] = below_nine[i-1] && nine[i-1];
        end
        assign cnt_inc[4*i +: 4] = (full || !below_nine[i]) ? d
                                   : (nine[i] ? 4'd0 : d + 4'd1);
    end

    assign full = below_nine[LINE_DIGITS-1] && nine[LINE_DIGITS-1];

    assign o_load         = i_accept && !drop;
    assign o_desc.has_pfx = do_num || blank_pfx;
    assign o_desc.dollar  = i_cfg.show_ends && ch_nl;
    assign o_desc.exp     = tslf_pkg::f_expand(i_in_byte, i_cfg.show_tabs,
                                               i_cfg.show_nonprinting);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_byte  <= tslf_pkg::CH_NL;
            r_line_count <= CNT_ONE;
            r_blank_run  <= 2'd0;
        end else if (i_accept) begin
            r_prev_byte  <= i_in_byte;
            r_line_count <= do_num ? cnt_inc : eff_cnt;
            r_blank_run  <= n_blank_run;
        end
    end

endmodule

// File: rtl/core/tslf_ser.sv
// Output serializer of the line formatter: holds one item's descriptor and
// shifts its bytes into the output register, one per cycle while unstalled.
// Depends on tslf_pkg.
`timescale 1ns / 1ps

module tslf_ser #(
    parameter int LINE_DIGITS = tslf_pkg::LINE_DIGITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_load,
    input  tslf_pkg::t_desc          i_desc,
    input  logic [8*LINE_DIGITS-1:0] i_pfx,
    input  logic                     i_stall,
    output logic                     o_ready,
    output logic                     o_valid,
    output logic [7:0]               o_out_byte,
    output logic                     o_last_of_run
);

    localparam int RW = $clog2(LINE_DIGITS + 2);
    localparam logic [RW-1:0] PFX_LEN = RW'(LINE_DIGITS + 1);

    logic                     r_d_valid;
    logic [RW-1:0]            r_rem_pfx;
    logic                     r_dollar;
    logic [2:0]               r_exp_left;
    logic [8*LINE_DIGITS-1:0] r_pfx;
    logic [3:0][7:0]          r_exp;
    logic                     r_o_valid;
    logic [7:0]               r_o_byte;
    logic                     r_o_last;

    logic       out_free;
    logic       move;
    logic       last;
    logic [7:0] cur_byte;

    assign out_free = !r_o_valid || !i_stall;
    assign move     = r_d_valid && out_free;
    assign last     = (r_rem_pfx == '0) && !r_dollar && (r_exp_left == 3'd1);
    assign o_ready  = !r_d_valid || (move && last);

    always_comb begin
        if (r_rem_pfx == RW'(1)) begin
            cur_byte = tslf_pkg::CH_TAB;
        end else if (r_rem_pfx != '0) begin
            cur_byte = r_pfx[8*LINE_DIGITS-1 -: 8];
        end else if (r_dollar) begin
            cur_byte = tslf_pkg::CH_DOLLAR;
        end else begin
            cur_byte = r_exp[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid  <= 1'b0;
            r_o_valid  <= 1'b0;
            r_rem_pfx  <= '0;
            r_dollar   <= 1'b0;
            r_exp_left <= 3'd0;
        end else begin
            if (move) begin
                r_o_valid <= 1'b1;
            end else if (out_free) begin
                r_o_valid <= 1'b0;
            end
            if (i_load) begin
                r_d_valid  <= 1'b1;
                r_rem_pfx  <= i_desc.has_pfx ? PFX_LEN : '0;
                r_dollar   <= i_desc.dollar;
                r_exp_left <= i_desc.exp.len;
            end else if (move) begin
                if (last) begin
                    r_d_valid <= 1'b0;
                end
                if (r_rem_pfx != '0) begin
                    r_rem_pfx <= r_rem_pfx - RW'(1);
                end else if (r_dollar) begin
                    r_dollar <= 1'b0;
                end else begin
                    r_exp_left <= r_exp_left - 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_o_byte <= cur_byte;
            r_o_last <= last;
        end
        if (i_load) begin
            r_pfx <= i_pfx;
            r_exp <= i_desc.exp.bytes;
        end else if (move) begin
            if (r_rem_pfx > RW'(1)) begin
                r_pfx <= r_pfx << 8;
            end else if (r_rem_pfx == '0 && !r_dollar) begin
                r_exp <= {r_exp[2:0], 8'h00};
            end
        end
    end

    assign o_valid       = r_o_valid;
    assign o_out_byte    = r_o_byte;
    assign o_last_of_run = r_o_last;

    a_load_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_ready)
        else $error("descriptor loaded while the serializer is busy");

    a_exp_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d_valid |-> (r_exp_left != 3'd0 && r_exp_left <= 3'd4))
        else $error("held item has no expansion bytes left");

    a_pfx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rem_pfx <= PFX_LEN)
        else $error("prefix count out of range");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (move && last && !i_load) |=> !r_d_valid && r_o_last)
        else $error("final byte of an item did not release the descriptor");

endmodule

// File: rtl/core/text_stream_line_formatter_unit.sv
// Top level of the text stream line formatter: configuration registers,
// front stage and output serializer. Depends on tslf_pkg, tslf_front, tslf_ser.
`timescale 1ns / 1ps

// The formatter takes one raw text byte per item and delivers its formatted
// expansion as a run of output items, the last one flagged by o_last_of_run.
// An input item is taken in the cycle it is offered as long as the output
// serializer is free or is handing over the final byte of the previous item,
// so the block sustains one input item per cycle for bytes that expand to one
// character when the output side does not stall. An item that expands to N
// characters (one to LINE_DIGITS+5, e.g. a line number prefix plus "M-^?")
// occupies the serializer until its last character is placed, one character
// per cycle into the output register while the output side does not stall;
// the input stall then holds off the next item. A squeezed blank line produces
// no output. An accepted item is registered in the serializer before its
// first byte moves to the output register. Configuration registers are
// written through i_cfg_we/i_cfg_idx/i_cfg_data and should only change while
// no item is in flight; i_start_of_file resets the line state before its byte.

module text_stream_line_formatter_unit #(
    parameter int LINE_DIGITS = tslf_pkg::LINE_DIGITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tslf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tslf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [7:0]                     i_in_byte,
    input  logic                           i_start_of_file,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [7:0]                     o_out_byte,
    output logic                           o_last_of_run
);

    tslf_pkg::t_cfg           r_cfg;
    tslf_pkg::t_desc          desc;
    logic [8*LINE_DIGITS-1:0] pfx;
    logic                     ser_ready;
    logic                     accept;
    logic                     load;

    // Writes to indexes beyond the register list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tslf_pkg::CFG_SQUEEZE_BLANK:    r_cfg.squeeze_blank    <= i_cfg_data[0];
                tslf_pkg::CFG_NUMBER_NONBLANK:  r_cfg.number_nonblank  <= i_cfg_data[0];
                tslf_pkg::CFG_NUMBER_ALL:       r_cfg.number_all       <= i_cfg_data[0];
                tslf_pkg::CFG_SHOW_ENDS:        r_cfg.show_ends        <= i_cfg_data[0];
                tslf_pkg::CFG_SHOW_TABS:        r_cfg.show_tabs        <= i_cfg_data[0];
                tslf_pkg::CFG_SHOW_NONPRINTING: r_cfg.show_nonprinting <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // The input is held off only while the serializer still owes bytes of
    // an earlier item beyond the one it moves out this cycle.
    assign accept  = i_valid && ser_ready;
    assign o_stall = !ser_ready;

    tslf_front #(
        .LINE_DIGITS (LINE_DIGITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_accept        (accept),
        .i_in_byte       (i_in_byte),
        .i_start_of_file (i_start_of_file),
        .o_load          (load),
        .o_desc          (desc),
        .o_pfx           (pfx)
    );

    tslf_ser #(
        .LINE_DIGITS (LINE_DIGITS)
    ) u_ser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (load),
        .i_desc        (desc),
        .i_pfx         (pfx),
        .i_stall       (i_stall),
        .o_ready       (ser_ready),
        .o_valid       (o_valid),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run)
    );

endmodule
